@@ rtl/core/bfp_pkg.sv @@
package bfp_pkg;

    // Timing and hysteresis constants of the protection scheme.
    localparam int unsigned TRIP_DELAY = 3;
    localparam int unsigned VOLT_HYST  = 50;
    localparam int unsigned TEMP_HYST  = 5;
    localparam int unsigned CNT_MAX    = 7;

    localparam int unsigned CNT_W      = 3;
    localparam int unsigned N_TRIP     = 10;
    localparam int unsigned N_REL      = 2;

    // Configuration port geometry and register indexes.
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 64;

    localparam logic [CFG_IDX_W-1:0] CFG_GROUP_MASK  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_VOLT_LIMITS = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CURR_LIMITS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TEMP_LIMITS = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PERM_LIMITS = 3'd4;

    localparam logic [3:0] GROUP_MASK_RESET = 4'hF;

    // Pack mode codes.
    localparam logic [1:0] MODE_CHG = 2'd1;
    localparam logic [1:0] MODE_DSG = 2'd2;

    // Trip counter slots, in fault word bit order.
    localparam int unsigned TC_OVP  = 0;
    localparam int unsigned TC_UVP  = 1;
    localparam int unsigned TC_COCP = 2;
    localparam int unsigned TC_DOCP = 3;
    localparam int unsigned TC_COTP = 4;
    localparam int unsigned TC_CUTP = 5;
    localparam int unsigned TC_DOTP = 6;
    localparam int unsigned TC_DUTP = 7;
    localparam int unsigned TC_CPF  = 8;
    localparam int unsigned TC_DPF  = 9;

    // Release counter slots.
    localparam int unsigned RC_VOLT = 0;
    localparam int unsigned RC_TEMP = 1;

    typedef enum logic [4:0] {
        EV_NONE      = 5'd0,
        EV_OVP_TRIP  = 5'd1,
        EV_UVP_TRIP  = 5'd2,
        EV_COCP_TRIP = 5'd3,
        EV_DOCP_TRIP = 5'd4,
        EV_COTP_TRIP = 5'd5,
        EV_CUTP_TRIP = 5'd6,
        EV_DOTP_TRIP = 5'd7,
        EV_DUTP_TRIP = 5'd8,
        EV_CPF_TRIP  = 5'd9,
        EV_DPF_TRIP  = 5'd10,
        EV_OVP_REL   = 5'd11,
        EV_UVP_REL   = 5'd12,
        EV_COCP_REL  = 5'd13,
        EV_DOCP_REL  = 5'd14,
        EV_COTP_REL  = 5'd15,
        EV_CUTP_REL  = 5'd16,
        EV_DOTP_REL  = 5'd17,
        EV_DUTP_REL  = 5'd18
    } t_event;

    typedef struct packed {
        logic [3:0]  group_enable_mask;
        logic [31:0] voltage_limits;
        logic [31:0] current_limits;
        logic [31:0] temperature_limits;
        logic [63:0] permanent_fault_limits;
    } t_cfg;

    typedef struct packed {
        logic [15:0]        max_cell_mv;
        logic [15:0]        min_cell_mv;
        logic [15:0]        diff_cell_mv;
        logic signed [31:0] current_sum;
        logic signed [7:0]  max_temp;
        logic signed [7:0]  min_temp;
        logic [1:0]         pack_mode;
    } t_item;

    typedef struct packed {
        logic [1:0]                     volt_faults;
        logic [1:0]                     curr_faults;
        logic [3:0]                     temp_faults;
        logic [1:0]                     perm_faults;
        logic [N_TRIP-1:0][CNT_W-1:0]   trip_cnt;
        logic [N_REL-1:0][CNT_W-1:0]    rel_cnt;
    } t_state;

    typedef struct packed {
        logic [9:0] fault_word;
        logic [4:0] event_code;
        logic       charge_fet_on;
        logic       discharge_fet_on;
    } t_result;

    // One tick of a delay counter: a true condition counts up and saturates,
    // a false one clears. The top bit of the result flags the delay passed.
    function automatic logic [CNT_W:0] cnt_step(input logic cond,
                                                 input logic [CNT_W-1:0] cnt);
        logic [CNT_W-1:0] nxt;
        nxt = '0;
        if (cond) begin
            nxt = (cnt < CNT_W'(CNT_MAX)) ? cnt + CNT_W'(1) : cnt;
        end
        return {cond && (nxt > CNT_W'(TRIP_DELAY)), nxt};
    endfunction

endpackage

@@ rtl/core/bfp_in_if.sv @@
interface bfp_in_if;
    logic               valid;
    logic               ready;
    logic [15:0]        max_cell_mv;
    logic [15:0]        min_cell_mv;
    logic [15:0]        diff_cell_mv;
    logic signed [31:0] current_sum;
    logic signed [7:0]  max_temp;
    logic signed [7:0]  min_temp;
    logic [1:0]         pack_mode;

    modport source (
        output valid, max_cell_mv, min_cell_mv, diff_cell_mv, current_sum,
               max_temp, min_temp, pack_mode,
        input  ready
    );
    modport sink (
        input  valid, max_cell_mv, min_cell_mv, diff_cell_mv, current_sum,
               max_temp, min_temp, pack_mode,
        output ready
    );
endinterface

@@ rtl/core/bfp_out_if.sv @@
interface bfp_out_if;
    logic       valid;
    logic       ready;
    logic [9:0] fault_word;
    logic [4:0] event_code;
    logic       charge_fet_on;
    logic       discharge_fet_on;

    modport source (
        output valid, fault_word, event_code, charge_fet_on, discharge_fet_on,
        input  ready
    );
    modport sink (
        input  valid, fault_word, event_code, charge_fet_on, discharge_fet_on,
        output ready
    );
endinterface

@@ rtl/core/bfp_cfg.sv @@
module bfp_cfg (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [bfp_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [bfp_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    output bfp_pkg::t_cfg                      o_cfg
);

    bfp_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.group_enable_mask      <= bfp_pkg::GROUP_MASK_RESET;
            r_cfg.voltage_limits         <= '0;
            r_cfg.current_limits         <= '0;
            r_cfg.temperature_limits     <= '0;
            r_cfg.permanent_fault_limits <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                bfp_pkg::CFG_GROUP_MASK:  r_cfg.group_enable_mask      <= i_cfg_data[3:0];
                bfp_pkg::CFG_VOLT_LIMITS: r_cfg.voltage_limits         <= i_cfg_data[31:0];
                bfp_pkg::CFG_CURR_LIMITS: r_cfg.current_limits         <= i_cfg_data[31:0];
                bfp_pkg::CFG_TEMP_LIMITS: r_cfg.temperature_limits     <= i_cfg_data[31:0];
                bfp_pkg::CFG_PERM_LIMITS: r_cfg.permanent_fault_limits <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

@@ rtl/core/bfp_eval.sv @@
module bfp_eval (
    input  bfp_pkg::t_cfg    i_cfg,
    input  bfp_pkg::t_item   i_item,
    input  bfp_pkg::t_state  i_state,
    output bfp_pkg::t_state  o_state,
    output bfp_pkg::t_result o_result
);

    logic               chg;
    logic               dsg;
    logic [15:0]        ovp;
    logic [15:0]        uvp;
    logic signed [15:0] cocp;
    logic signed [15:0] docp;
    logic signed [7:0]  cot;
    logic signed [7:0]  cut;
    logic signed [7:0]  dot;
    logic signed [7:0]  dut;
    logic [15:0]        pcc;
    logic [15:0]        pcd;
    logic [15:0]        pdc;
    logic [15:0]        pdd;
    logic signed [8:0]  tmax9;
    logic signed [8:0]  tmin9;
    logic [16:0]        vmax17;
    logic [16:0]        vmin17;

    assign chg  = (i_item.pack_mode == bfp_pkg::MODE_CHG);
    assign dsg  = (i_item.pack_mode == bfp_pkg::MODE_DSG);
    assign ovp  = i_cfg.voltage_limits[31:16];
    assign uvp  = i_cfg.voltage_limits[15:0];
    assign cocp = i_cfg.current_limits[31:16];
    assign docp = i_cfg.current_limits[15:0];
    assign cot  = i_cfg.temperature_limits[31:24];
    assign cut  = i_cfg.temperature_limits[23:16];
    assign dot  = i_cfg.temperature_limits[15:8];
    assign dut  = i_cfg.temperature_limits[7:0];
    assign pcc  = i_cfg.permanent_fault_limits[63:48];
    assign pcd  = i_cfg.permanent_fault_limits[47:32];
    assign pdc  = i_cfg.permanent_fault_limits[31:16];
    assign pdd  = i_cfg.permanent_fault_limits[15:0];

    assign tmax9  = {i_item.max_temp[7], i_item.max_temp};
    assign tmin9  = {i_item.min_temp[7], i_item.min_temp};
    assign vmax17 = {1'b0, i_item.max_cell_mv};
    assign vmin17 = {1'b0, i_item.min_cell_mv};

    // Hysteresis compares, rearranged so nothing can wrap.
    logic rel_ovp, rel_uvp, rel_cotp, rel_cutp, rel_dotp, rel_dutp;

    assign rel_ovp  = (vmax17 + 17'(bfp_pkg::VOLT_HYST)) < {1'b0, ovp};
    assign rel_uvp  = vmin17 > ({1'b0, uvp} + 17'(bfp_pkg::VOLT_HYST));
    assign rel_cotp = (tmax9 + $signed(9'(bfp_pkg::TEMP_HYST))) < $signed({cot[7], cot});
    assign rel_dotp = (tmax9 + $signed(9'(bfp_pkg::TEMP_HYST))) < $signed({dot[7], dot});
    assign rel_cutp = tmin9 > ($signed({cut[7], cut}) + $signed(9'(bfp_pkg::TEMP_HYST)));
    assign rel_dutp = tmin9 > ($signed({dut[7], dut}) + $signed(9'(bfp_pkg::TEMP_HYST)));

    bfp_pkg::t_state       st;
    bfp_pkg::t_event       ev;
    logic                  cfet;
    logic                  dfet;
    logic [bfp_pkg::CNT_W:0] s;

    always_comb begin
        st   = i_state;
        ev   = bfp_pkg::EV_NONE;
        cfet = 1'b0;
        dfet = 1'b0;
        s    = '0;

        // Trip checks, in group order; a later event overwrites the code.
        if (i_cfg.group_enable_mask[0] && (st.volt_faults == 2'b00)) begin
            s = bfp_pkg::cnt_step(i_item.max_cell_mv > ovp, st.trip_cnt[bfp_pkg::TC_OVP]);
            st.trip_cnt[bfp_pkg::TC_OVP] = s[bfp_pkg::CNT_W-1:0];
            if (s[bfp_pkg::CNT_W]) begin
                st.volt_faults[0] = 1'b1;
                ev = bfp_pkg::EV_OVP_TRIP;
            end
            s = bfp_pkg::cnt_step(i_item.min_cell_mv < uvp, st.trip_cnt[bfp_pkg::TC_UVP]);
            st.trip_cnt[bfp_pkg::TC_UVP] = s[bfp_pkg::CNT_W-1:0];
            if (s[bfp_pkg::CNT_W]) begin
                st.volt_faults[1] = 1'b1;
                ev = bfp_pkg::EV_UVP_TRIP;
            end
        end

        if (i_cfg.group_enable_mask[1] && (st.curr_faults == 2'b00)) begin
            if (chg) begin
                s = bfp_pkg::cnt_step(i_item.current_sum > cocp,
                                      st.trip_cnt[bfp_pkg::TC_COCP]);
                st.trip_cnt[bfp_pkg::TC_COCP] = s[bfp_pkg::CNT_W-1:0];
                if (s[bfp_pkg::CNT_W]) begin
                    st.curr_faults[0] = 1'b1;
                    ev = bfp_pkg::EV_COCP_TRIP;
                end
            end else if (dsg) begin
                s = bfp_pkg::cnt_step(i_item.current_sum < docp,
                                      st.trip_cnt[bfp_pkg::TC_DOCP]);
                st.trip_cnt[bfp_pkg::TC_DOCP] = s[bfp_pkg::CNT_W-1:0];
                if (s[bfp_pkg::CNT_W]) begin
                    st.curr_faults[1] = 1'b1;
                    ev = bfp_pkg::EV_DOCP_TRIP;
                end
            end
        end

        if (i_cfg.group_enable_mask[2] && (st.temp_faults == 4'b0000)) begin
            if (chg) begin
                s = bfp_pkg::cnt_step(i_item.max_temp > cot, st.trip_cnt[bfp_pkg::TC_COTP]);
                st.trip_cnt[bfp_pkg::TC_COTP] = s[bfp_pkg::CNT_W-1:0];
                if (s[bfp_pkg::CNT_W]) begin
                    st.temp_faults[0] = 1'b1;
                    ev = bfp_pkg::EV_COTP_TRIP;
                end
                s = bfp_pkg::cnt_step(i_item.min_temp < cut, st.trip_cnt[bfp_pkg::TC_CUTP]);
                st.trip_cnt[bfp_pkg::TC_CUTP] = s[bfp_pkg::CNT_W-1:0];
                if (s[bfp_pkg::CNT_W]) begin
                    st.temp_faults[1] = 1'b1;
                    ev = bfp_pkg::EV_CUTP_TRIP;
                end
            end else if (dsg) begin
                s = bfp_pkg::cnt_step(i_item.max_temp > dot, st.trip_cnt[bfp_pkg::TC_DOTP]);
                st.trip_cnt[bfp_pkg::TC_DOTP] = s[bfp_pkg::CNT_W-1:0];
                if (s[bfp_pkg::CNT_W]) begin
                    st.temp_faults[2] = 1'b1;
                    ev = bfp_pkg::EV_DOTP_TRIP;
                end
                s = bfp_pkg::cnt_step(i_item.min_temp < dut, st.trip_cnt[bfp_pkg::TC_DUTP]);
                st.trip_cnt[bfp_pkg::TC_DUTP] = s[bfp_pkg::CNT_W-1:0];
                if (s[bfp_pkg::CNT_W]) begin
                    st.temp_faults[3] = 1'b1;
                    ev = bfp_pkg::EV_DUTP_TRIP;
                end
            end
        end

        if (i_cfg.group_enable_mask[3] && (st.perm_faults == 2'b00)) begin
            if (chg) begin
                s = bfp_pkg::cnt_step((i_item.max_cell_mv > pcc) && (i_item.diff_cell_mv > pcd),
                                      st.trip_cnt[bfp_pkg::TC_CPF]);
                st.trip_cnt[bfp_pkg::TC_CPF] = s[bfp_pkg::CNT_W-1:0];
                if (s[bfp_pkg::CNT_W]) begin
                    st.perm_faults[0] = 1'b1;
                    ev = bfp_pkg::EV_CPF_TRIP;
                end
            end
            if (dsg) begin
                s = bfp_pkg::cnt_step((i_item.min_cell_mv > pdc) && (i_item.diff_cell_mv > pdd),
                                      st.trip_cnt[bfp_pkg::TC_DPF]);
                st.trip_cnt[bfp_pkg::TC_DPF] = s[bfp_pkg::CNT_W-1:0];
                if (s[bfp_pkg::CNT_W]) begin
                    st.perm_faults[1] = 1'b1;
                    ev = bfp_pkg::EV_DPF_TRIP;
                end
            end
        end

        // Releases see the faults as they stand after this tick's trips.
        if (st.volt_faults == 2'b01) begin
            s = bfp_pkg::cnt_step(rel_ovp, st.rel_cnt[bfp_pkg::RC_VOLT]);
            st.rel_cnt[bfp_pkg::RC_VOLT] = s[bfp_pkg::CNT_W-1:0];
            if (s[bfp_pkg::CNT_W]) begin
                st.volt_faults = 2'b00;
                ev   = bfp_pkg::EV_OVP_REL;
                cfet = 1'b1;
            end
        end else if (st.volt_faults == 2'b10) begin
            s = bfp_pkg::cnt_step(rel_uvp, st.rel_cnt[bfp_pkg::RC_VOLT]);
            st.rel_cnt[bfp_pkg::RC_VOLT] = s[bfp_pkg::CNT_W-1:0];
            if (s[bfp_pkg::CNT_W]) begin
                st.volt_faults = 2'b00;
                ev   = bfp_pkg::EV_UVP_REL;
                dfet = 1'b1;
            end
        end

        // Current faults clear as soon as the mode reverses.
        if (st.curr_faults == 2'b01) begin
            if (dsg) begin
                st.curr_faults = 2'b00;
                ev   = bfp_pkg::EV_COCP_REL;
                cfet = 1'b1;
            end
        end else if (st.curr_faults == 2'b10) begin
            if (chg) begin
                st.curr_faults = 2'b00;
                ev   = bfp_pkg::EV_DOCP_REL;
                dfet = 1'b1;
            end
        end

        if (st.temp_faults == 4'b0001) begin
            s = bfp_pkg::cnt_step(rel_cotp, st.rel_cnt[bfp_pkg::RC_TEMP]);
            st.rel_cnt[bfp_pkg::RC_TEMP] = s[bfp_pkg::CNT_W-1:0];
            if (s[bfp_pkg::CNT_W]) begin
                st.temp_faults = 4'b0000;
                ev   = bfp_pkg::EV_COTP_REL;
                cfet = 1'b1;
            end
        end else if (st.temp_faults == 4'b0100) begin
            s = bfp_pkg::cnt_step(rel_dotp, st.rel_cnt[bfp_pkg::RC_TEMP]);
            st.rel_cnt[bfp_pkg::RC_TEMP] = s[bfp_pkg::CNT_W-1:0];
            if (s[bfp_pkg::CNT_W]) begin
                st.temp_faults = 4'b0000;
                ev   = bfp_pkg::EV_DOTP_REL;
                dfet = 1'b1;
            end
        end else if (st.temp_faults == 4'b0010) begin
            s = bfp_pkg::cnt_step(rel_cutp, st.rel_cnt[bfp_pkg::RC_TEMP]);
            st.rel_cnt[bfp_pkg::RC_TEMP] = s[bfp_pkg::CNT_W-1:0];
            if (s[bfp_pkg::CNT_W]) begin
                st.temp_faults = 4'b0000;
                ev   = bfp_pkg::EV_CUTP_REL;
                cfet = 1'b1;
            end
        end else if (st.temp_faults == 4'b1000) begin
            s = bfp_pkg::cnt_step(rel_dutp, st.rel_cnt[bfp_pkg::RC_TEMP]);
            st.rel_cnt[bfp_pkg::RC_TEMP] = s[bfp_pkg::CNT_W-1:0];
            if (s[bfp_pkg::CNT_W]) begin
                st.temp_faults = 4'b0000;
                ev   = bfp_pkg::EV_DUTP_REL;
                dfet = 1'b1;
            end
        end
    end

    assign o_state                   = st;
    assign o_result.fault_word       = {st.perm_faults, st.temp_faults,
                                        st.curr_faults, st.volt_faults};
    assign o_result.event_code       = ev;
    assign o_result.charge_fet_on    = cfet;
    assign o_result.discharge_fet_on = dfet;

endmodule

@@ rtl/core/battery_fault_protection.sv @@
// Battery pack protection fault latch.
// Each item on i_item carries one one-second tick of pack readings: highest,
// lowest and spread of cell voltage, summed pack current, highest and lowest
// temperature, and the charge/discharge mode. For every item exactly one
// result leaves on o_result: the latched fault word after the tick, the
// code of the last trip or release event, and flags that tell
// firmware to re-enable the charge or discharge FET.
// Limits and the group enable mask are written through the plain write port
// (i_cfg_we, i_cfg_idx, i_cfg_data); the user must write them only while no
// item is in flight; the block does not enforce it. An accepted item waits in
// the input register, then the compare-and-count logic feeds the result
// register and the fault state together. One item is taken every cycle while
// the receiver does not stall; each needs a single pass of fault evaluation.
// When the receiver stalls, the result register holds its item and the input
// register still takes one more item; only then does i_item.ready drop.
// Reset is synchronous and active low: it clears all faults and delay
// counters, empties both registers, enables all four fault groups and sets
// every limit to zero.
module battery_fault_protection (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    bfp_in_if.sink                             i_item,
    bfp_out_if.source                          o_result,
    input  logic                               i_cfg_we,
    input  logic [bfp_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [bfp_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    bfp_pkg::t_cfg    w_cfg;
    bfp_pkg::t_item   r_in;
    logic             r_in_valid;
    bfp_pkg::t_state  r_state;
    bfp_pkg::t_state  n_state;
    bfp_pkg::t_result r_out;
    bfp_pkg::t_result n_out;
    logic             r_out_valid;
    logic             w_adv;
    logic             w_in_ready;

    bfp_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (w_cfg)
    );

    // The held item moves into the result register when that register is
    // empty or is being emptied in this cycle.
    assign w_adv      = r_in_valid && (!r_out_valid || o_result.ready);
    assign w_in_ready = !r_in_valid || w_adv;
    assign i_item.ready = w_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_ready) begin
            r_in_valid <= i_item.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_item.valid && w_in_ready) begin
            r_in.max_cell_mv  <= i_item.max_cell_mv;
            r_in.min_cell_mv  <= i_item.min_cell_mv;
            r_in.diff_cell_mv <= i_item.diff_cell_mv;
            r_in.current_sum  <= i_item.current_sum;
            r_in.max_temp     <= i_item.max_temp;
            r_in.min_temp     <= i_item.min_temp;
            r_in.pack_mode    <= i_item.pack_mode;
        end
    end

    bfp_eval u_eval (
        .i_cfg    (w_cfg),
        .i_item   (r_in),
        .i_state  (r_state),
        .o_state  (n_state),
        .o_result (n_out)
    );

    // Fault flags and delay counters move only with an item.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (w_adv) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out <= n_out;
        end
    end

    assign o_result.valid            = r_out_valid;
    assign o_result.fault_word       = r_out.fault_word;
    assign o_result.event_code       = r_out.event_code;
    assign o_result.charge_fet_on    = r_out.charge_fet_on;
    assign o_result.discharge_fet_on = r_out.discharge_fet_on;

    // Permanent faults, once latched, never clear outside reset.
    a_perm_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        1'b1 |=> ((r_state.perm_faults & $past(r_state.perm_faults))
                  == $past(r_state.perm_faults)))
        else $error("permanent fault cleared");

    // The protection state moves only when an item is evaluated.
    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_adv |=> $stable(r_state))
        else $error("fault state changed without an item");

    // A FET re-enable pulse comes only with a release as the last event.
    a_fet_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out.charge_fet_on || r_out.discharge_fet_on))
        |-> (r_out.event_code >= 5'(bfp_pkg::EV_OVP_REL)))
        else $error("FET pulse without a release event");

    // The fault word shown is the state left by the item just evaluated.
    a_word_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv |=> (r_out.fault_word == {r_state.perm_faults, r_state.temp_faults,
                                        r_state.curr_faults, r_state.volt_faults}))
        else $error("fault word does not match latched state");

endmodule

@@ bench/tb_battery_fault_protection.sv @@
module tb_battery_fault_protection;

    import bfp_pkg::*;

    // Pack mode codes that the package leaves unnamed.
    localparam logic [1:0] MODE_IDLE  = 2'd0;
    localparam logic [1:0] MODE_UNDEF = 2'd3;

    // Bits of the group enable mask.
    localparam int GRP_VOLT = 0;
    localparam int GRP_CURR = 1;
    localparam int GRP_TEMP = 2;
    localparam int GRP_PERM = 3;

    // Latched fault bits inside each group.
    localparam logic [1:0] VOLT_OV  = 2'b01;
    localparam logic [1:0] VOLT_UV  = 2'b10;
    localparam logic [1:0] CURR_CHG = 2'b01;
    localparam logic [1:0] CURR_DSG = 2'b10;
    localparam logic [3:0] TEMP_COT = 4'b0001;
    localparam logic [3:0] TEMP_CUT = 4'b0010;
    localparam logic [3:0] TEMP_DOT = 4'b0100;
    localparam logic [3:0] TEMP_DUT = 4'b1000;
    localparam logic [1:0] PERM_CHG = 2'b01;
    localparam logic [1:0] PERM_DSG = 2'b10;

    // A plausible pack setup: 4.2 V / 3.0 V cell limits, +/-1000 current
    // limits, 45/0 degrees when charging and 60/-20 when discharging.
    localparam logic [31:0] VOLT_NOMINAL = {16'd4200, 16'd3000};
    localparam logic [31:0] CURR_NOMINAL = {16'h03E8, 16'hFC18};
    localparam logic [31:0] TEMP_NOMINAL = {8'd45, 8'd0, 8'd60, 8'hEC};
    // Permanent fault limits low enough that ordinary readings reach them.
    localparam logic [63:0] PERM_REACHABLE = {16'd3900, 16'd200, 16'd3100, 16'd200};

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    bfp_in_if  tick_if ();
    bfp_out_if status_if ();

    battery_fault_protection uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_item     (tick_if),
        .o_result   (status_if),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    // Our own copy of the configuration registers, as they were last written.
    logic [3:0]  grp_mask = GROUP_MASK_RESET;
    logic [31:0] volt_lim = '0;
    logic [31:0] curr_lim = '0;
    logic [31:0] temp_lim = '0;
    logic [63:0] perm_lim = '0;

    // Mirror of the protection state: latched faults and delay counters.
    logic [1:0] volt_flt = '0;
    logic [1:0] curr_flt = '0;
    logic [3:0] temp_flt = '0;
    logic [1:0] perm_flt = '0;
    logic [CNT_W-1:0] trip_cnt [N_TRIP] = '{default: '0};
    logic [CNT_W-1:0] hold_cnt [N_REL]  = '{default: '0};

    // Readings waiting to be sent, and the status words they must produce.
    t_item   pending_ticks [$];
    t_result expected_status [$];

    t_item   drv_tick;
    t_item   sent_tick;
    t_result want;
    int      sender_gap;
    int      receiver_gap;
    logic    quiet = 1'b0;
    int      errors = 0;

    // One tick of a trip delay counter. A false condition clears the count; a
    // true one counts up, saturating, and reports when the delay is exceeded.
    function automatic logic trip_count(logic cond, int slot);
        if (!cond) begin
            trip_cnt[slot] = '0;
            return 1'b0;
        end
        if (trip_cnt[slot] < CNT_W'(CNT_MAX)) begin
            trip_cnt[slot] = trip_cnt[slot] + CNT_W'(1);
        end
        return trip_cnt[slot] > CNT_W'(TRIP_DELAY);
    endfunction

    // The same for the hysteresis counters that time a release.
    function automatic logic hold_count(logic cond, int slot);
        if (!cond) begin
            hold_cnt[slot] = '0;
            return 1'b0;
        end
        if (hold_cnt[slot] < CNT_W'(CNT_MAX)) begin
            hold_cnt[slot] = hold_cnt[slot] + CNT_W'(1);
        end
        return hold_cnt[slot] > CNT_W'(TRIP_DELAY);
    endfunction

    // Works out the status word of one tick and advances the mirrored state.
    // Trip checks run group by group, then the releases; the event code keeps
    // whatever happened last. Releases run even for disabled groups.
    function automatic t_result evaluate_tick(t_item it);
        int vmax, vmin, vdif, amps, tmax, tmin;
        int ovp, uvp, cocp, docp, chg_hot, chg_cold, dsg_hot, dsg_cold;
        int pf_chg_cell, pf_chg_diff, pf_dsg_cell, pf_dsg_diff;
        int volt_band, temp_band;
        logic chg, dsg, cfet, dfet;
        t_event ev;
        t_result res;
        vmax = int'(it.max_cell_mv);
        vmin = int'(it.min_cell_mv);
        vdif = int'(it.diff_cell_mv);
        amps = it.current_sum;
        tmax = it.max_temp;
        tmin = it.min_temp;
        chg = (it.pack_mode == MODE_CHG);
        dsg = (it.pack_mode == MODE_DSG);
        ovp = int'(volt_lim[31:16]);
        uvp = int'(volt_lim[15:0]);
        cocp = int'($signed(curr_lim[31:16]));
        docp = int'($signed(curr_lim[15:0]));
        chg_hot  = int'($signed(temp_lim[31:24]));
        chg_cold = int'($signed(temp_lim[23:16]));
        dsg_hot  = int'($signed(temp_lim[15:8]));
        dsg_cold = int'($signed(temp_lim[7:0]));
        pf_chg_cell = int'(perm_lim[63:48]);
        pf_chg_diff = int'(perm_lim[47:32]);
        pf_dsg_cell = int'(perm_lim[31:16]);
        pf_dsg_diff = int'(perm_lim[15:0]);
        volt_band = int'(VOLT_HYST);
        temp_band = int'(TEMP_HYST);
        ev = EV_NONE;
        cfet = 1'b0;
        dfet = 1'b0;

        if (grp_mask[GRP_VOLT] && volt_flt == '0) begin
            if (trip_count(vmax > ovp, TC_OVP)) begin
                volt_flt |= VOLT_OV;
                ev = EV_OVP_TRIP;
            end
            if (trip_count(vmin < uvp, TC_UVP)) begin
                volt_flt |= VOLT_UV;
                ev = EV_UVP_TRIP;
            end
        end
        if (grp_mask[GRP_CURR] && curr_flt == '0) begin
            if (chg) begin
                if (trip_count(amps > cocp, TC_COCP)) begin
                    curr_flt |= CURR_CHG;
                    ev = EV_COCP_TRIP;
                end
            end else if (dsg) begin
                if (trip_count(amps < docp, TC_DOCP)) begin
                    curr_flt |= CURR_DSG;
                    ev = EV_DOCP_TRIP;
                end
            end
        end
        if (grp_mask[GRP_TEMP] && temp_flt == '0) begin
            if (chg) begin
                if (trip_count(tmax > chg_hot, TC_COTP)) begin
                    temp_flt |= TEMP_COT;
                    ev = EV_COTP_TRIP;
                end
                if (trip_count(tmin < chg_cold, TC_CUTP)) begin
                    temp_flt |= TEMP_CUT;
                    ev = EV_CUTP_TRIP;
                end
            end else if (dsg) begin
                if (trip_count(tmax > dsg_hot, TC_DOTP)) begin
                    temp_flt |= TEMP_DOT;
                    ev = EV_DOTP_TRIP;
                end
                if (trip_count(tmin < dsg_cold, TC_DUTP)) begin
                    temp_flt |= TEMP_DUT;
                    ev = EV_DUTP_TRIP;
                end
            end
        end
        if (grp_mask[GRP_PERM] && perm_flt == '0) begin
            if (chg) begin
                if (trip_count(vmax > pf_chg_cell && vdif > pf_chg_diff, TC_CPF)) begin
                    perm_flt |= PERM_CHG;
                    ev = EV_CPF_TRIP;
                end
            end
            if (dsg) begin
                if (trip_count(vmin > pf_dsg_cell && vdif > pf_dsg_diff, TC_DPF)) begin
                    perm_flt |= PERM_DSG;
                    ev = EV_DPF_TRIP;
                end
            end
        end

        // A group with both of its faults latched matches no release below.
        if (volt_flt == VOLT_OV) begin
            if (hold_count(vmax < ovp - volt_band, RC_VOLT)) begin
                volt_flt = '0;
                ev = EV_OVP_REL;
                cfet = 1'b1;
            end
        end else if (volt_flt == VOLT_UV) begin
            if (hold_count(vmin > uvp + volt_band, RC_VOLT)) begin
                volt_flt = '0;
                ev = EV_UVP_REL;
                dfet = 1'b1;
            end
        end
        if (curr_flt == CURR_CHG) begin
            if (dsg) begin
                curr_flt = '0;
                ev = EV_COCP_REL;
                cfet = 1'b1;
            end
        end else if (curr_flt == CURR_DSG) begin
            if (chg) begin
                curr_flt = '0;
                ev = EV_DOCP_REL;
                dfet = 1'b1;
            end
        end
        if (temp_flt == TEMP_COT) begin
            if (hold_count(tmax < chg_hot - temp_band, RC_TEMP)) begin
                temp_flt = '0;
                ev = EV_COTP_REL;
                cfet = 1'b1;
            end
        end else if (temp_flt == TEMP_DOT) begin
            if (hold_count(tmax < dsg_hot - temp_band, RC_TEMP)) begin
                temp_flt = '0;
                ev = EV_DOTP_REL;
                dfet = 1'b1;
            end
        end else if (temp_flt == TEMP_CUT) begin
            if (hold_count(tmin > chg_cold + temp_band, RC_TEMP)) begin
                temp_flt = '0;
                ev = EV_CUTP_REL;
                cfet = 1'b1;
            end
        end else if (temp_flt == TEMP_DUT) begin
            if (hold_count(tmin > dsg_cold + temp_band, RC_TEMP)) begin
                temp_flt = '0;
                ev = EV_DUTP_REL;
                dfet = 1'b1;
            end
        end

        res.fault_word = {perm_flt, temp_flt, curr_flt, volt_flt};
        res.event_code = ev;
        res.charge_fet_on = cfet;
        res.discharge_fet_on = dfet;
        return res;
    endfunction

    // Wait before the next item or the next result. Quiet phases run the
    // channels back to back so that the block also sees full throughput.
    function automatic int draw_gap();
        return quiet ? 0 : int'($urandom_range(0, 9));
    endfunction

    function automatic logic [15:0] clip_mv(int v);
        if (v < 0) return 16'd0;
        if (v > 65535) return 16'hFFFF;
        return 16'(v);
    endfunction

    function automatic logic signed [7:0] clip_deg(int v);
        if (v < -128) return -8'sd128;
        if (v > 127) return 8'sd127;
        return 8'(v);
    endfunction

    function automatic t_item reading(logic [15:0] vmax, logic [15:0] vmin,
                                      logic [15:0] vdif, logic signed [31:0] amps,
                                      logic signed [7:0] tmax, logic signed [7:0] tmin,
                                      logic [1:0] mode);
        t_item it;
        it.max_cell_mv = vmax;
        it.min_cell_mv = vmin;
        it.diff_cell_mv = vdif;
        it.current_sum = amps;
        it.max_temp = tmax;
        it.min_temp = tmin;
        it.pack_mode = mode;
        return it;
    endfunction

    // Queues a run of ticks that hold one mode and one kind of excursion, so
    // that faults really build up over consecutive ticks and then release.
    // Readings sit near the limits in force, with a small jitter per tick.
    // Within a run at most one voltage limit and one temperature limit of the
    // active mode is approached; a double fault would lock its group for good.
    task automatic queue_run(int len);
        logic [1:0] mode;
        int pick, vplan, tplan, voff, toff, coff, doff, vmargin, tmargin;
        int ovp, uvp, hot, cold, amp_lim, dif_lim, jv, jt;
        logic [15:0] vmax, vmin;
        logic signed [7:0] tmax, tmin;
        logic signed [31:0] amps;
        pick = $urandom_range(0, 9);
        if (pick < 4) mode = MODE_CHG;
        else if (pick < 8) mode = MODE_DSG;
        else if (pick == 8) mode = MODE_IDLE;
        else mode = MODE_UNDEF;
        ovp = int'(volt_lim[31:16]);
        uvp = int'(volt_lim[15:0]);
        if (mode == MODE_DSG) begin
            hot = int'($signed(temp_lim[15:8]));
            cold = int'($signed(temp_lim[7:0]));
            amp_lim = int'($signed(curr_lim[15:0]));
            dif_lim = int'(perm_lim[15:0]);
        end else begin
            hot = int'($signed(temp_lim[31:24]));
            cold = int'($signed(temp_lim[23:16]));
            amp_lim = int'($signed(curr_lim[31:16]));
            dif_lim = int'(perm_lim[47:32]);
        end
        vplan = $urandom_range(0, 9);
        tplan = $urandom_range(0, 9);
        voff = int'($urandom_range(0, 160)) - 80;
        toff = int'($urandom_range(0, 16)) - 8;
        coff = int'($urandom_range(0, 6000)) - 3000;
        doff = int'($urandom_range(0, 200)) - 100;
        vmargin = 60 + int'($urandom_range(0, 200));
        tmargin = 6 + int'($urandom_range(0, 10));
        for (int k = 0; k < len; k++) begin
            jv = int'($urandom_range(0, 6)) - 3;
            jt = int'($urandom_range(0, 2)) - 1;
            if (vplan >= 4 && vplan < 7) begin
                vmax = clip_mv(ovp + voff + jv);
                vmin = clip_mv(uvp + vmargin);
            end else if (vplan >= 7) begin
                vmax = clip_mv(ovp - vmargin);
                vmin = clip_mv(uvp + voff + jv);
            end else begin
                vmax = clip_mv(ovp - vmargin + jv);
                vmin = clip_mv(uvp + vmargin - jv);
            end
            if (tplan >= 4 && tplan < 7) begin
                tmax = clip_deg(hot + toff + jt);
                tmin = clip_deg(cold + tmargin);
            end else if (tplan >= 7) begin
                tmax = clip_deg(hot - tmargin);
                tmin = clip_deg(cold + toff + jt);
            end else begin
                tmax = clip_deg(hot - tmargin + jt);
                tmin = clip_deg(cold + tmargin - jt);
            end
            // Now and then a wild current, which drives every bit of the sum.
            if ($urandom_range(0, 9) == 0) amps = $urandom;
            else amps = amp_lim + coff + int'($urandom_range(0, 100)) - 50;
            pending_ticks.push_back(reading(vmax, vmin, clip_mv(dif_lim + doff + jv),
                                            amps, tmax, tmin, mode));
        end
    endtask

    // Configuration is only touched while the block is idle.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        case (idx)
            CFG_GROUP_MASK:  grp_mask = data[3:0];
            CFG_VOLT_LIMITS: volt_lim = data[31:0];
            CFG_CURR_LIMITS: curr_lim = data[31:0];
            CFG_TEMP_LIMITS: temp_lim = data[31:0];
            CFG_PERM_LIMITS: perm_lim = data;
            default: ;
        endcase
    endtask

    task automatic program_limits(logic [3:0] mask, logic [31:0] vlim, logic [31:0] clim,
                                  logic [31:0] tlim, logic [63:0] plim);
        write_reg(CFG_GROUP_MASK, CFG_DATA_W'(mask));
        write_reg(CFG_VOLT_LIMITS, CFG_DATA_W'(vlim));
        write_reg(CFG_CURR_LIMITS, CFG_DATA_W'(clim));
        write_reg(CFG_TEMP_LIMITS, CFG_DATA_W'(tlim));
        write_reg(CFG_PERM_LIMITS, plim);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    // Holds the sender back until every status word is in, then allows for
    // the input and result registers before anything else happens.
    task automatic wait_drained();
        while (pending_ticks.size() != 0 || expected_status.size() != 0 || tick_if.valid) begin
            @(negedge i_clk);
        end
        repeat (4) @(posedge i_clk);
    endtask

    // Sender: presents queued ticks, taking a fresh gap before each one. The
    // status word is predicted at the edge where the tick is accepted.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            tick_if.valid <= 1'b0;
            sender_gap = draw_gap();
        end else begin
            if (tick_if.valid && tick_if.ready) begin
                sent_tick = reading(tick_if.max_cell_mv, tick_if.min_cell_mv,
                                    tick_if.diff_cell_mv, tick_if.current_sum,
                                    tick_if.max_temp, tick_if.min_temp, tick_if.pack_mode);
                expected_status.push_back(evaluate_tick(sent_tick));
            end
            if (!tick_if.valid || tick_if.ready) begin
                if (sender_gap > 0) begin
                    sender_gap--;
                    tick_if.valid <= 1'b0;
                end else if (pending_ticks.size() != 0) begin
                    drv_tick = pending_ticks.pop_front();
                    tick_if.valid <= 1'b1;
                    tick_if.max_cell_mv <= drv_tick.max_cell_mv;
                    tick_if.min_cell_mv <= drv_tick.min_cell_mv;
                    tick_if.diff_cell_mv <= drv_tick.diff_cell_mv;
                    tick_if.current_sum <= drv_tick.current_sum;
                    tick_if.max_temp <= drv_tick.max_temp;
                    tick_if.min_temp <= drv_tick.min_temp;
                    tick_if.pack_mode <= drv_tick.pack_mode;
                    sender_gap = draw_gap();
                end else begin
                    tick_if.valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: stalls at random and checks each status word, field by
    // field, against the oldest prediction.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            status_if.ready <= 1'b0;
            receiver_gap = draw_gap();
        end else begin
            if (status_if.valid && status_if.ready) begin
                if (expected_status.size() == 0) begin
                    $error("status word with no tick outstanding: fault_word %h",
                           status_if.fault_word);
                    errors++;
                end else begin
                    want = expected_status.pop_front();
                    if (status_if.fault_word !== want.fault_word) begin
                        $error("fault_word: expected %h, got %h",
                               want.fault_word, status_if.fault_word);
                        errors++;
                    end
                    if (status_if.event_code !== want.event_code) begin
                        $error("event_code: expected %0d, got %0d",
                               want.event_code, status_if.event_code);
                        errors++;
                    end
                    if (status_if.charge_fet_on !== want.charge_fet_on) begin
                        $error("charge_fet_on: expected %b, got %b",
                               want.charge_fet_on, status_if.charge_fet_on);
                        errors++;
                    end
                    if (status_if.discharge_fet_on !== want.discharge_fet_on) begin
                        $error("discharge_fet_on: expected %b, got %b",
                               want.discharge_fet_on, status_if.discharge_fet_on);
                        errors++;
                    end
                end
                receiver_gap = draw_gap();
            end
            if (receiver_gap > 0) begin
                receiver_gap--;
                status_if.ready <= 1'b0;
            end else begin
                status_if.ready <= 1'b1;
            end
        end
    end

    // Sequence of the run: reset, a directed opening, then eight phases of
    // random runs under different limit settings, each drained before the
    // limits change.
    initial begin
        int queued;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        tick_if.valid = 1'b0;
        tick_if.max_cell_mv = '0;
        tick_if.min_cell_mv = '0;
        tick_if.diff_cell_mv = '0;
        tick_if.current_sum = '0;
        tick_if.max_temp = '0;
        tick_if.min_temp = '0;
        tick_if.pack_mode = MODE_IDLE;
        status_if.ready = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed opening under the nominal limits, permanent checks off.
        program_limits(4'b0111, VOLT_NOMINAL, CURR_NOMINAL, TEMP_NOMINAL, PERM_REACHABLE);
        // Extremes of every field, including both idle codes.
        pending_ticks.push_back(reading(16'd0, 16'd0, 16'd0, 32'sd0, 8'sd0, 8'sd0,
                                        MODE_IDLE));
        pending_ticks.push_back(reading(16'hFFFF, 16'hFFFF, 16'hFFFF, 32'h7FFFFFFF,
                                        8'sd127, 8'sd127, MODE_UNDEF));
        pending_ticks.push_back(reading(16'd3700, 16'd3600, 16'd20, 32'h80000000,
                                        -8'sd128, -8'sd128, MODE_IDLE));
        pending_ticks.push_back(reading(16'd3700, 16'd3600, 16'd20, 32'sd500, 8'sd25, 8'sd20,
                                        MODE_CHG));
        // Overvoltage: four ticks above the limit trip it, four ticks below the
        // hysteresis band release it and pulse the charge FET enable.
        repeat (4) pending_ticks.push_back(reading(16'd4250, 16'd3600, 16'd20, 32'sd500,
                                                   8'sd25, 8'sd20, MODE_CHG));
        repeat (4) pending_ticks.push_back(reading(16'd4100, 16'd3600, 16'd20, 32'sd500,
                                                   8'sd25, 8'sd20, MODE_CHG));
        // Charge overcurrent trips, then clears on the first discharge tick.
        repeat (4) pending_ticks.push_back(reading(16'd3700, 16'd3600, 16'd20, 32'sd2000,
                                                   8'sd25, 8'sd20, MODE_CHG));
        pending_ticks.push_back(reading(16'd3700, 16'd3600, 16'd20, -32'sd500, 8'sd25, 8'sd20,
                                        MODE_DSG));
        // Discharge overtemperature trips and releases past the 5 degree band.
        repeat (4) pending_ticks.push_back(reading(16'd3700, 16'd3600, 16'd20, -32'sd500,
                                                   8'sd70, 8'sd20, MODE_DSG));
        repeat (4) pending_ticks.push_back(reading(16'd3700, 16'd3600, 16'd20, -32'sd500,
                                                   8'sd50, 8'sd20, MODE_DSG));
        wait_drained();

        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0: program_limits(4'b0111, VOLT_NOMINAL, CURR_NOMINAL, TEMP_NOMINAL,
                                  PERM_REACHABLE);
                // Random but sane limits, permanent checks off.
                1, 5: program_limits(4'($urandom_range(1, 7)),
                                     {16'($urandom_range(3800, 4500)),
                                      16'($urandom_range(2500, 3400))},
                                     {16'($urandom_range(100, 30000)),
                                      16'(-int'($urandom_range(100, 30000)))},
                                     {8'($urandom_range(30, 70)),
                                      8'(int'($urandom_range(0, 40)) - 30),
                                      8'($urandom_range(40, 90)),
                                      8'(int'($urandom_range(0, 50)) - 50)},
                                     {$urandom, $urandom});
                // Every group disabled: only releases of leftover faults happen.
                2: program_limits(4'b0000, VOLT_NOMINAL, CURR_NOMINAL, TEMP_NOMINAL,
                                  PERM_REACHABLE);
                // Widest limits: voltage, temperature and permanent never trip,
                // current only beyond the 16-bit range.
                3: program_limits(4'b1111, 32'hFFFF0000, 32'h7FFF8000, 32'h7F807F80, '1);
                // Zero voltage and current limits: anything above zero trips,
                // and an overvoltage cannot release until the limit moves.
                4: program_limits(4'b1111, 32'd0, 32'd0, TEMP_NOMINAL, '1);
                6: program_limits(4'b0111, VOLT_NOMINAL, CURR_NOMINAL, TEMP_NOMINAL,
                                  PERM_REACHABLE);
                default: program_limits(4'b1111, VOLT_NOMINAL, CURR_NOMINAL, TEMP_NOMINAL,
                                        PERM_REACHABLE);
            endcase
            quiet = (ph == 1 || ph == 6);
            queued = 0;
            while (queued < 125) begin
                pick_len: begin
                    int len;
                    len = $urandom_range(1, 10);
                    queue_run(len);
                    queued += len;
                end
            end
            if (ph == 7) begin
                // Both faults of the voltage group and both charge temperature
                // faults at once; neither group may ever release afterwards.
                repeat (5) pending_ticks.push_back(reading(16'd4300, 16'd2900, 16'd20,
                                                           32'sd500, 8'sd55, -8'sd10,
                                                           MODE_CHG));
                queue_run(8);
            end
            wait_drained();
        end

        if (errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // Watchdog: set far beyond the slowest legal run.
    initial begin
        #2000000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
